>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files of the merge block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define KWM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kwm check failed");

// Clocked assertion that is also evaluated during reset.
`define KWM_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("kwm reset check failed");

`endif

>>> rtl/kwm_pkg.sv
// Constants and types of the k-way sorted merge block.
package kwm_pkg;

  // Sizing of the merge
  localparam int SOURCES    = 8;
  localparam int WORD_BITS  = 64;
  localparam int SRC_W      = $clog2(SOURCES);
  localparam int CNT_W      = $clog2(SOURCES + 1);
  localparam int LEAVES     = 1 << SRC_W;

  // Fixed field widths of the channels
  localparam int IN_WORD_W  = 64;
  localparam int OUT_WORD_W = 64;
  localparam int IDX_W      = 3;

  // Configuration port
  localparam int CFG_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCES_IN_USE = 2'd0;
  localparam logic [CFG_W-1:0]      SOURCES_RESET      = 4'd8;

  // Operation codes of an input beat
  localparam logic OP_WORD = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [SRC_W-1:0]     src_t;

  typedef struct packed {
    word_t            merged_value;
    logic             value_present;
    logic [IDX_W-1:0] next_source;
    logic             merge_done;
    logic             protocol_error;
  } result_t;

endpackage

>>> rtl/kwm_in_if.sv
// Input channel of the merge block: one word or end marker per beat.
interface kwm_in_if;
  import kwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [IDX_W-1:0]     source_index;
  logic [IN_WORD_W-1:0] word_value;

  modport source (output valid, operation, source_index, word_value, input ready);
  modport sink   (input valid, operation, source_index, word_value, output ready);
endinterface

>>> rtl/kwm_out_if.sv
// Result channel of the merge block: one merged word or status per beat.
interface kwm_out_if;
  import kwm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OUT_WORD_W-1:0] merged_value;
  logic                  value_present;
  logic [IDX_W-1:0]      next_source;
  logic                  merge_done;
  logic                  protocol_error;

  modport source (output valid, merged_value, value_present, next_source, merge_done,
                  protocol_error, input ready);
  modport sink   (input valid, merged_value, value_present, next_source, merge_done,
                  protocol_error, output ready);
endinterface

>>> rtl/k_way_sorted_merge.sv
// K-way sorted merge: top level with head store, comparator tree and APB register.
//
// Usage: in_s carries beats of (operation, source_index, word_value); a word
// beat loads that source's head, an end beat marks the source finished.
// While priming, every source in use (register sources_in_use, APB address 0)
// sends one beat in any order; only error results appear until all have done so.
// Afterwards each beat must come from the source named by next_source of the
// previous result, and each beat gives one result with the smallest head.
// A beat from the wrong source, or a second priming beat, is dropped and a
// result with protocol_error set is returned. When every source has ended, a
// result with merge_done set closes the merge and the block re-arms.
// A beat passes the input register and then the result register to reach out_s.
// Throughput: one beat per cycle while out_s takes results, set by the head update
// and the log2(SOURCES)-level comparator tree that closes the state loop.
// Reset (synchronous, rst_n low) clears all heads and flags, enters priming
// and sets sources_in_use to 8; head words themselves are not cleared.
// When out_s stalls, the result register holds; one more beat is held in the
// input register, then in_s.ready drops until the result is taken.
module k_way_sorted_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  kwm_in_if.sink                          in_s,
  kwm_out_if.source                       out_s,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [kwm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [kwm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [kwm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import kwm_pkg::*;

  // Input register
  logic              in_valid_r;
  logic              in_op_r;
  logic [IDX_W-1:0]  in_src_r;
  word_t             in_word_r;

  // Result register
  logic              out_valid_r;
  result_t           res_r;

  // Merge state
  word_t             hw_r [SOURCES];
  logic [SOURCES-1:0] hv_r, hv_nxt;
  logic [SOURCES-1:0] se_r, se_nxt;
  logic              priming_r, priming_nxt;
  src_t              awaited_r, awaited_nxt;
  logic [CFG_W-1:0]  sources_r;

  // Combinational work
  logic              advance;
  logic [CNT_W-1:0]  n_use;
  logic [SOURCES-1:0] use_mask;
  logic [SOURCES-1:0] open_mask;
  logic              open_any;
  src_t              first_open;
  src_t              s_idx;
  logic              err;
  logic              wr_en;
  logic [SOURCES-1:0] hv_upd, se_upd;
  logic              all_primed;
  logic              do_emit;
  word_t             node_val [1:2*LEAVES-1];
  logic              node_ok  [1:2*LEAVES-1];
  src_t              node_idx [1:2*LEAVES-1];
  logic              best_ok;
  word_t             best_val;
  src_t              best_idx;
  result_t           res_nxt;
  logic              res_load;

  // Handshake: the input register drains whenever the result slot is free
  assign advance    = in_valid_r && (!out_valid_r || out_s.ready);
  assign in_s.ready = !in_valid_r || advance;

  // APB register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_SOURCES_IN_USE) ?
                      CFG_DATA_W'(sources_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sources_r <= SOURCES_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      sources_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // Effective source count, clamped to 1..SOURCES
  always_comb begin
    if (sources_r == '0) begin
      n_use = CNT_W'(1);
    end else if (32'(sources_r) > SOURCES) begin
      n_use = CNT_W'(SOURCES);
    end else begin
      n_use = CNT_W'(sources_r);
    end
    for (int i = 0; i < SOURCES; i++) begin
      use_mask[i] = (CNT_W'(i) < n_use);
    end
  end

  // Beat check and head update
  always_comb begin
    s_idx      = SRC_W'(in_src_r);
    open_mask  = ~hv_r & ~se_r & use_mask;
    open_any   = |open_mask;
    first_open = '0;
    for (int i = SOURCES - 1; i >= 0; i--) begin
      if (open_mask[i]) begin
        first_open = SRC_W'(i);
      end
    end
    if (priming_r) begin
      err = (32'(in_src_r) >= 32'(n_use)) || hv_r[s_idx] || se_r[s_idx];
    end else begin
      err = (32'(in_src_r) != 32'(awaited_r));
    end
    hv_upd = hv_r;
    se_upd = se_r;
    wr_en  = 1'b0;
    if (!err) begin
      if (in_op_r == OP_END) begin
        se_upd[s_idx] = 1'b1;
      end else begin
        hv_upd[s_idx] = 1'b1;
        wr_en         = 1'b1;
      end
    end
    all_primed = ~|(~hv_upd & ~se_upd & use_mask);
    do_emit    = !err && (!priming_r || all_primed);
  end

  // Minimum tree over the updated heads; ties go to the lower index
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < SOURCES) begin
        node_val[LEAVES+i] = (wr_en && s_idx == SRC_W'(i)) ? in_word_r : hw_r[i];
        node_ok[LEAVES+i]  = hv_upd[i] && use_mask[i];
      end else begin
        node_val[LEAVES+i] = '0;
        node_ok[LEAVES+i]  = 1'b0;
      end
      node_idx[LEAVES+i] = SRC_W'(i);
    end
    for (int k = LEAVES - 1; k >= 1; k--) begin
      if (node_ok[2*k+1] && (!node_ok[2*k] || node_val[2*k+1] < node_val[2*k])) begin
        node_val[k] = node_val[2*k+1];
        node_idx[k] = node_idx[2*k+1];
      end else begin
        node_val[k] = node_val[2*k];
        node_idx[k] = node_idx[2*k];
      end
      node_ok[k] = node_ok[2*k] || node_ok[2*k+1];
    end
    best_ok  = node_ok[1];
    best_val = node_val[1];
    best_idx = node_idx[1];
  end

  // Next state and result
  always_comb begin
    hv_nxt      = hv_r;
    se_nxt      = se_r;
    priming_nxt = priming_r;
    awaited_nxt = awaited_r;
    res_nxt     = '0;
    res_load    = 1'b0;
    if (advance) begin
      if (err) begin
        res_load               = 1'b1;
        res_nxt.protocol_error = 1'b1;
        res_nxt.next_source    = (priming_r && open_any) ? IDX_W'(first_open) :
                                                           IDX_W'(awaited_r);
      end else begin
        hv_nxt = hv_upd;
        se_nxt = se_upd;
        if (do_emit) begin
          res_load = 1'b1;
          if (!best_ok) begin
            // every source has ended: close the merge and re-arm
            hv_nxt             = '0;
            se_nxt             = '0;
            priming_nxt        = 1'b1;
            awaited_nxt        = '0;
            res_nxt.merge_done = 1'b1;
          end else begin
            hv_nxt[best_idx]      = 1'b0;
            awaited_nxt           = best_idx;
            priming_nxt           = 1'b0;
            res_nxt.merged_value  = best_val;
            res_nxt.value_present = 1'b1;
            res_nxt.next_source   = IDX_W'(best_idx);
          end
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hv_r        <= '0;
      se_r        <= '0;
      priming_r   <= 1'b1;
      awaited_r   <= '0;
    end else begin
      if (in_s.ready) begin
        in_valid_r <= in_s.valid;
      end
      if (advance) begin
        out_valid_r <= res_load;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
      hv_r      <= hv_nxt;
      se_r      <= se_nxt;
      priming_r <= priming_nxt;
      awaited_r <= awaited_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      in_op_r   <= in_s.operation;
      in_src_r  <= in_s.source_index;
      in_word_r <= in_s.word_value[WORD_BITS-1:0];
    end
    if (advance && res_load) begin
      res_r <= res_nxt;
    end
    if (advance && wr_en) begin
      hw_r[s_idx] <= in_word_r;
    end
  end

  // Result channel
  assign out_s.valid          = out_valid_r;
  assign out_s.merged_value   = OUT_WORD_W'(res_r.merged_value);
  assign out_s.value_present  = res_r.value_present;
  assign out_s.next_source    = res_r.next_source;
  assign out_s.merge_done     = res_r.merge_done;
  assign out_s.protocol_error = res_r.protocol_error;

endmodule

>>> rtl/kwm_checker.sv
// Port-level checks of the merge block, bound to its top level.
`include "assert_macros.svh"

module kwm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [kwm_pkg::OUT_WORD_W-1:0]  merged_value,
  input logic                            value_present,
  input logic                            merge_done,
  input logic                            protocol_error
);
  import kwm_pkg::*;

  logic done_clean;
  assign done_clean = !value_present && !protocol_error && merged_value == '0;

  // a stalled result beat stays offered
  `KWM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  // closing beat carries no word and no error
  `KWM_ASSERT(a_done_clean, clk, rst_n, out_valid && merge_done |-> done_clean)
  // a dropped beat never carries a word or closes the merge
  `KWM_ASSERT(a_err_clean, clk, rst_n, out_valid && protocol_error |-> !value_present && !merge_done)
  // with the result slot empty, the input side is never held off
  `KWM_ASSERT(a_ready_free, clk, rst_n, !out_valid |-> in_ready)
  // reset empties the result register
  `KWM_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid)

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_s.ready),
  .out_valid      (out_s.valid),
  .out_ready      (out_s.ready),
  .merged_value   (out_s.merged_value),
  .value_present  (out_s.value_present),
  .merge_done     (out_s.merge_done),
  .protocol_error (out_s.protocol_error)
);

>>> tb/k_way_sorted_merge_tb.sv
// Self-checking testbench of the k-way sorted merge: directed table, random merges, scoreboard.
module k_way_sorted_merge_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kwm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int BEAT_TARGET = 1350;
  localparam int PHASE_BEATS = 110;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 8;
  localparam word_t MAXW = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    src_t        src;
    word_t       word;
    check_kind_t check;
    result_t     typed;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  kwm_in_if  beat_if ();
  kwm_out_if res_if ();

  k_way_sorted_merge u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (beat_if),
    .out_s       (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Merge state as the predictor sees it
  word_t            heads      [SOURCES];
  bit               head_full  [SOURCES];
  bit               src_done   [SOURCES];
  bit               in_priming = 1'b1;
  src_t             awaited_src = '0;
  logic [CFG_W-1:0] live_cfg = SOURCES_RESET;

  // Scoreboard
  result_t merge_out_q [$];
  int      err_count = 0;
  int      beats_taken = 0;
  int      merges_closed = 0;
  int      idle_cycles = 0;
  bit      long_hold_done = 1'b0;

  // Checking mode of the beat on the channel, set by the sender with the beat
  check_kind_t beat_check = CHK_MODEL;
  result_t     beat_typed = '0;

  // Sender state
  int        burst_left = 0;
  int        plan_left [SOURCES];
  word_t     floor_w   [SOURCES];
  stim_row_t dir_rows  [$];

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int live_sources();
    if (live_cfg == 0) return 1;
    if (live_cfg > SOURCES) return SOURCES;
    return int'(live_cfg);
  endfunction

  function automatic result_t outcome(word_t v, logic p, int nx, logic d, logic e);
    result_t r;
    r.merged_value   = v;
    r.value_present  = p;
    r.next_source    = nx[IDX_W-1:0];
    r.merge_done     = d;
    r.protocol_error = e;
    return r;
  endfunction

  function automatic stim_row_t mk_beat(logic op, int src, word_t w, check_kind_t ck,
                                        result_t r);
    stim_row_t row;
    row.kind  = ROW_BEAT;
    row.op    = op;
    row.src   = src[SRC_W-1:0];
    row.word  = w;
    row.check = ck;
    row.typed = r;
    return row;
  endfunction

  function automatic stim_row_t mk_cfg(int v);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.word = word_t'(v);
    return row;
  endfunction

  // Pop the smallest head (lowest index wins ties); with none left, close the merge
  function automatic void emit_smallest(output result_t r);
    int n;
    int best;
    int i;
    n    = live_sources();
    best = -1;
    r    = '0;
    for (i = 0; i < n; i++) begin
      if (head_full[i] && (best < 0 || heads[i] < heads[best])) best = i;
    end
    if (best < 0) begin
      for (i = 0; i < SOURCES; i++) begin
        head_full[i] = 1'b0;
        src_done[i]  = 1'b0;
      end
      in_priming  = 1'b1;
      awaited_src = '0;
      r.merge_done = 1'b1;
    end else begin
      head_full[best] = 1'b0;
      awaited_src     = src_t'(best);
      in_priming      = 1'b0;
      r.merged_value  = heads[best];
      r.value_present = 1'b1;
      r.next_source   = best[IDX_W-1:0];
    end
  endfunction

  // Advance the merge by one accepted beat; returns 1 when a result follows
  function automatic bit predict_merge(logic op, src_t s, word_t w, output result_t r);
    int n;
    int i;
    int first_open;
    bit all_in;
    n = live_sources();
    r = '0;
    if (in_priming) begin
      if (int'(s) >= n || head_full[s] || src_done[s]) begin
        first_open = n;
        for (i = n - 1; i >= 0; i--) begin
          if (!head_full[i] && !src_done[i]) first_open = i;
        end
        r.protocol_error = 1'b1;
        r.next_source    = (first_open < n) ? first_open[IDX_W-1:0] : awaited_src;
        return 1'b1;
      end
      if (op == OP_END) src_done[s] = 1'b1;
      else begin
        heads[s]     = w;
        head_full[s] = 1'b1;
      end
      all_in = 1'b1;
      for (i = 0; i < n; i++) begin
        if (!head_full[i] && !src_done[i]) all_in = 1'b0;
      end
      if (!all_in) return 1'b0;
      emit_smallest(r);
      return 1'b1;
    end
    if (s != awaited_src) begin
      r.protocol_error = 1'b1;
      r.next_source    = awaited_src;
      return 1'b1;
    end
    if (op == OP_END) src_done[s] = 1'b1;
    else begin
      heads[s]     = w;
      head_full[s] = 1'b1;
    end
    emit_smallest(r);
    return 1'b1;
  endfunction

  // Input beats feed the predictor; result beats are checked against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    result_t got;
    bit      some;
    if (rst_n) begin
      if (beat_if.valid && beat_if.ready) begin
        some = predict_merge(beat_if.operation, beat_if.source_index, beat_if.word_value,
                             want);
        if (some && want.merge_done) merges_closed++;
        if (beat_check == CHK_NONE) some = 1'b0;
        else if (beat_check == CHK_TYPED) begin
          some = 1'b1;
          want = beat_typed;
        end
        if (some) merge_out_q.insert(merge_out_q.size(), want);
        beats_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        got.merged_value   = res_if.merged_value;
        got.value_present  = res_if.value_present;
        got.next_source    = res_if.next_source;
        got.merge_done     = res_if.merge_done;
        got.protocol_error = res_if.protocol_error;
        if (merge_out_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result v=%h p=%b nx=%0d d=%b e=%b", $time,
                   got.merged_value, got.value_present, got.next_source,
                   got.merge_done, got.protocol_error);
        end else begin
          want = merge_out_q.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: result mismatch exp v=%h p=%b nx=%0d d=%b e=%b", $time,
                     want.merged_value, want.value_present, want.next_source,
                     want.merge_done, want.protocol_error);
            $display("%0t:                 got v=%h p=%b nx=%0d d=%b e=%b", $time,
                     got.merged_value, got.value_present, got.next_source,
                     got.merge_done, got.protocol_error);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if ((beat_if.valid && beat_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result sink: short random stalls, runs without stalls, one long hold-off
  initial begin
    int pick;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && beats_taken >= HOLD_AFTER) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          res_if.ready = 1'b0;
          repeat (pick < 13 ? $urandom_range(0, 2) : $urandom_range(10, 40)) @(negedge clk);
        end else begin
          res_if.ready = 1'b1;
          repeat (pick < 95 ? $urandom_range(0, 6) : $urandom_range(40, 100)) @(negedge clk);
        end
      end
    end
  end

  task automatic wait_drained();
    while (merge_out_q.size() != 0) @(posedge clk);
  endtask

  // Offer one beat, hold it until taken, then maybe leave a gap
  task automatic send_beat(logic op, src_t s, word_t w, check_kind_t ck, result_t r);
    int pick;
    int gap;
    beat_if.operation    = op;
    beat_if.source_index = s;
    beat_if.word_value   = w;
    beat_check           = ck;
    beat_typed           = r;
    beat_if.valid        = 1'b1;
    @(posedge clk);
    while (!beat_if.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 88) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 40);
      if (pick == 0) burst_left = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      beat_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Register write once the block has drained, then read back
  task automatic write_sources(logic [CFG_W-1:0] v);
    logic [CFG_DATA_W-1:0] rd;
    beat_if.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = REG_SOURCES_IN_USE;
    cfg_pwdata  = CFG_DATA_W'(v);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    live_cfg = v;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (rd !== CFG_DATA_W'(v)) begin
      err_count++;
      $display("%0t: sources_in_use readback exp %h got %h", $time, CFG_DATA_W'(v), rd);
    end
  endtask

  initial begin
    int    ph;
    int    phase_start;
    int    done_mark;
    int    n;
    int    i;
    int    phase_vals [$];
    int    open_srcs [$];
    bit    tie_mode;
    logic  op;
    src_t  s;
    word_t w;
    word_t step;

    rst_n                = 1'b0;
    beat_if.valid        = 1'b0;
    beat_if.operation    = OP_WORD;
    beat_if.source_index = '0;
    beat_if.word_value   = '0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: two-way merge with every error kind, count 0 as one way, count 15 as eight
    dir_rows = '{
      mk_cfg(2),
      mk_beat(OP_WORD, 0, MAXW, CHK_NONE, '0),
      mk_beat(OP_WORD, 0, 5, CHK_TYPED, outcome(0, 0, 1, 0, 1)),
      mk_beat(OP_WORD, 5, 9, CHK_TYPED, outcome(0, 0, 1, 0, 1)),
      mk_beat(OP_WORD, 1, 0, CHK_TYPED, outcome(0, 1, 1, 0, 0)),
      mk_beat(OP_WORD, 0, 4, CHK_TYPED, outcome(0, 0, 1, 0, 1)),
      mk_beat(OP_WORD, 1, MAXW, CHK_TYPED, outcome(MAXW, 1, 0, 0, 0)),
      mk_beat(OP_END, 0, 0, CHK_TYPED, outcome(MAXW, 1, 1, 0, 0)),
      mk_beat(OP_END, 1, 0, CHK_TYPED, outcome(0, 0, 0, 1, 0)),
      mk_cfg(0),
      mk_beat(OP_END, 0, 0, CHK_TYPED, outcome(0, 0, 0, 1, 0)),
      mk_beat(OP_WORD, 1, 7, CHK_TYPED, outcome(0, 0, 0, 0, 1)),
      mk_beat(OP_WORD, 0, 64'h8000_0000_0000_0000, CHK_TYPED,
              outcome(64'h8000_0000_0000_0000, 1, 0, 0, 0)),
      mk_beat(OP_END, 0, 0, CHK_TYPED, outcome(0, 0, 0, 1, 0)),
      mk_cfg(15),
      mk_beat(OP_WORD, 7, 64'hA5A5_A5A5_A5A5_A5A5, CHK_MODEL, '0),
      mk_beat(OP_END, 6, 0, CHK_MODEL, '0),
      mk_beat(OP_WORD, 5, 3, CHK_MODEL, '0),
      mk_beat(OP_WORD, 4, 3, CHK_MODEL, '0),
      mk_beat(OP_END, 3, MAXW, CHK_MODEL, '0),
      mk_beat(OP_WORD, 2, 64'h5A5A_5A5A_5A5A_5A5A, CHK_MODEL, '0),
      mk_beat(OP_WORD, 1, 1, CHK_MODEL, '0),
      mk_beat(OP_END, 0, 0, CHK_TYPED, outcome(1, 1, 1, 0, 0)),
      mk_beat(OP_END, 1, 0, CHK_TYPED, outcome(3, 1, 4, 0, 0)),
      mk_beat(OP_END, 4, 0, CHK_TYPED, outcome(3, 1, 5, 0, 0)),
      mk_beat(OP_END, 5, 0, CHK_TYPED, outcome(64'h5A5A_5A5A_5A5A_5A5A, 1, 2, 0, 0)),
      mk_beat(OP_END, 2, 0, CHK_TYPED, outcome(64'hA5A5_A5A5_A5A5_A5A5, 1, 7, 0, 0)),
      mk_beat(OP_END, 7, 0, CHK_TYPED, outcome(0, 0, 0, 1, 0))
    };
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) write_sources(dir_rows[r].word[CFG_W-1:0]);
      else send_beat(dir_rows[r].op, dir_rows[r].src, dir_rows[r].word,
                     dir_rows[r].check, dir_rows[r].typed);
    end

    // Random: phases of whole merges, each phase under its own source count
    phase_vals = '{8, 1, 15, 3, 0, 5, 2, 8, 7, 4, 6, 8};
    ph = 0;
    while (beats_taken < BEAT_TARGET) begin
      write_sources(CFG_W'(ph < phase_vals.size() ? phase_vals[ph] : $urandom_range(0, 15)));
      ph++;
      phase_start = beats_taken;
      while (beats_taken - phase_start < PHASE_BEATS) begin
        // plan stream lengths and starting words; narrow words force equal heads
        tie_mode = ($urandom_range(0, 3) == 0);
        for (i = 0; i < SOURCES; i++) begin
          plan_left[i] = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4)
                                                    : $urandom_range(5, 14);
          floor_w[i] = tie_mode ? word_t'($urandom_range(0, 3))
                                : ({$urandom, $urandom} >> $urandom_range(0, 63));
        end
        done_mark = merges_closed;
        while (merges_closed == done_mark) begin
          n = live_sources();
          if ($urandom_range(0, 9) == 0) begin
            // stray beat: any source, any operation
            op = 1'($urandom_range(0, 1));
            s  = src_t'($urandom_range(0, SOURCES - 1));
            w  = {$urandom, $urandom};
          end else begin
            if (in_priming) begin
              open_srcs.delete();
              for (i = 0; i < n; i++) begin
                if (!head_full[i] && !src_done[i]) open_srcs.insert(open_srcs.size(), i);
              end
              s = src_t'(open_srcs[$urandom_range(0, open_srcs.size() - 1)]);
            end else begin
              s = awaited_src;
            end
            if (plan_left[s] <= 0) begin
              op = OP_END;
              w  = {$urandom, $urandom};
            end else begin
              op = OP_WORD;
              step = tie_mode ? word_t'($urandom_range(0, 2))
                              : ({$urandom, $urandom} >> $urandom_range(8, 63));
              w = floor_w[s] + step;
              if (w < floor_w[s]) w = MAXW;
              floor_w[s] = w;
              plan_left[s]--;
            end
          end
          send_beat(op, s, w, CHK_MODEL, '0);
        end
      end
    end

    beat_if.valid = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
